### src/plti_pkg.sv
// Shared types, constants and codes for the piecewise-linear table interpolator.
`timescale 1ns / 1ps
package plti_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int DATA_W      = 32;

    // Radix-4 restoring divider: two quotient bits per cycle.
    localparam int DIV_BITS_PER_CYC = 2;
    localparam int DIV_CYC          = DATA_W / DIV_BITS_PER_CYC;
    localparam int DIV_CW           = $clog2(DIV_CYC);

    localparam int PADDR_W = 3;

    // Register index taken from paddr[2].
    localparam logic REG_ENTRIES_IN_USE = 1'b0;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_F2P   = 2'd1;
    localparam logic [1:0] OP_P2F   = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] ST_INTERP   = 2'd0;
    localparam logic [1:0] ST_CLAMP_LO = 2'd1;
    localparam logic [1:0] ST_CLAMP_HI = 2'd2;
    localparam logic [1:0] ST_WRITTEN  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_PREP,
        S_MUL,
        S_DIV
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [2*DATA_W-1:0]   dividend;
        logic [DATA_W-1:0]     divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DATA_W-1:0]     quotient;
    } t_div_rsp;

endpackage

### src/plti_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
module plti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/plti_div.sv
// Radix-4 restoring divider for a 64-bit dividend whose quotient fits in 32 bits.
`timescale 1ns / 1ps
module plti_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  plti_pkg::t_div_req i_req,
    output plti_pkg::t_div_rsp o_rsp
);
    import plti_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_low;
    logic [DATA_W-1:0] r_den;

    logic [DATA_W:0]   w_s1, w_s2;
    logic [DATA_W-1:0] w_rem1, w_rem2;
    logic              w_b1, w_b2;

    // Two dependent compare-and-subtract steps per cycle. The upper half of
    // the dividend is below the divisor, so the remainder stays in 32 bits.
    always_comb begin
        w_s1 = {r_rem, r_low[DATA_W-1]};
        w_b1 = (w_s1 >= {1'b0, r_den});
        w_rem1 = w_b1 ? DATA_W'(w_s1 - {1'b0, r_den}) : w_s1[DATA_W-1:0];
        w_s2 = {w_rem1, r_low[DATA_W-2]};
        w_b2 = (w_s2 >= {1'b0, r_den});
        w_rem2 = w_b2 ? DATA_W'(w_s2 - {1'b0, r_den}) : w_s2[DATA_W-1:0];
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
        end else if (r_busy && (r_cnt == DIV_CW'(DIV_CYC - 1))) begin
            n_busy = 1'b0;
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            if (i_req.start) begin
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= DIV_CW'(r_cnt + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend[2*DATA_W-1:DATA_W];
            r_low <= i_req.dividend[DATA_W-1:0];
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_rem2;
            r_low <= {r_low[DATA_W-3:0], w_b1, w_b2};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_low;

endmodule

### src/piecewise_linear_table_interp.sv
// Top level: position/force table lookup with linear interpolation.
`timescale 1ns / 1ps
// A write transaction answers in the cycle after it is accepted, and another can follow at once.
// A query clamped low answers once the first entry is checked; one clamped high once all entries in use are.
// An interpolated query answers after the walk to the bracketing entry, then S_PREP, S_MUL and the divider.
// The rate is set by the entry walk through the table RAM read port and the divider; busy holds off a new command.
// Synchronous reset sets entries_in_use to 2; the table contents are not cleared by reset.
module piecewise_linear_table_interp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command channel.
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_entry_index,
    input  logic [31:0] i_entry_position,
    input  logic [31:0] i_entry_force,
    input  logic [31:0] i_query_value,
    // Result channel.
    output logic        o_done,
    output logic [31:0] o_result_value,
    output logic [1:0]  o_status,
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [plti_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import plti_pkg::*;

    // Control state.
    t_state     r_state, n_state;
    logic       r_done;
    logic [4:0] r_entries;

    // Per-transaction working registers.
    logic signed [DATA_W-1:0] r_q;
    logic                     r_p2f;
    logic [TBL_AW-1:0]        r_idx;
    logic [TBL_AW-1:0]        r_last;
    logic signed [DATA_W-1:0] r_k0;
    logic signed [DATA_W-1:0] r_v0;
    logic [DATA_W-1:0]        r_num;
    logic [DATA_W-1:0]        r_den;
    logic [DATA_W:0]          r_dv;
    logic [DATA_W-1:0]        r_mag;
    logic                     r_neg;
    logic [DATA_W-1:0]        r_result;
    logic [1:0]               r_status;

    logic                     w_accept;
    logic                     w_cfg_wr;
    logic [TBL_AW-1:0]        w_cfg_last;
    logic                     w_we;
    logic [TBL_AW-1:0]        w_raddr;
    logic [DATA_W-1:0]        w_pos_rd, w_frc_rd;
    logic signed [DATA_W-1:0] w_key, w_val;
    logic                     w_hit, w_first, w_last;
    t_div_req                 w_div_req;
    t_div_rsp                 w_div_rsp;

    assign w_accept = start && !busy;
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // Configuration register and read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= 5'd2;
        end else if (w_cfg_wr && (paddr[2] == REG_ENTRIES_IN_USE)) begin
            r_entries <= pwdata[4:0];
        end
    end

    assign prdata = (paddr[2] == REG_ENTRIES_IN_USE) ? {27'd0, r_entries} : 32'd0;

    // The searched entry count is clamped into two through the table depth; only its
    // last index is kept for the walk.
    always_comb begin
        if (r_entries < 5'd2) begin
            w_cfg_last = TBL_AW'(1);
        end else if (32'(r_entries) > TABLE_DEPTH) begin
            w_cfg_last = TBL_AW'(TABLE_DEPTH - 1);
        end else begin
            w_cfg_last = TBL_AW'(r_entries - 5'd1);
        end
    end

    // Both columns share one address, so each walk cycle reads a whole entry.
    plti_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_entry_index[TBL_AW-1:0]),
        .i_wdata (i_entry_position),
        .i_raddr (w_raddr),
        .o_rdata (w_pos_rd)
    );

    plti_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_frc_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_entry_index[TBL_AW-1:0]),
        .i_wdata (i_entry_force),
        .i_raddr (w_raddr),
        .o_rdata (w_frc_rd)
    );

    plti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // A position-to-force query searches the position column; a force-to-position
    // query searches the force column.
    assign w_key   = r_p2f ? $signed(w_pos_rd) : $signed(w_frc_rd);
    assign w_val   = r_p2f ? $signed(w_frc_rd) : $signed(w_pos_rd);
    assign w_hit   = (r_q <= w_key);
    assign w_first = (r_idx == '0);
    assign w_last  = (r_idx == r_last);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && ((i_opcode == OP_F2P) || (i_opcode == OP_P2F))) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (w_hit) begin
                    n_state = w_first ? S_IDLE : S_PREP;
                end else if (w_last) begin
                    n_state = S_IDLE;
                end
            end
            S_PREP: n_state = S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs. During the walk the next entry is requested while the
    // current one is checked; the read issued in the final walk cycle goes unused.
    always_comb begin
        busy      = (r_state != S_IDLE);
        w_we      = w_accept && (i_opcode == OP_WRITE) && (32'(i_entry_index) < TABLE_DEPTH);
        w_raddr   = (r_state == S_WALK) ? TBL_AW'(r_idx + 1'b1) : '0;
        w_div_req.start    = (r_state == S_MUL);
        w_div_req.dividend = r_num * r_mag;
        w_div_req.divisor  = r_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: r_done <= w_accept && (i_opcode == OP_WRITE);
                S_WALK: r_done <= (w_hit && w_first) || (!w_hit && w_last);
                S_DIV:  r_done <= w_div_rsp.done;
                default: r_done <= 1'b0;
            endcase
        end
    end

    // Datapath. The bracketing entry gives 0 < q-k0 <= k1-k0, so the quotient is
    // no larger than |v1-v0| and v0 plus or minus it never overflows.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_q      <= $signed(i_query_value);
                    r_p2f    <= (i_opcode == OP_P2F);
                    r_idx    <= '0;
                    r_last   <= w_cfg_last;
                    r_result <= '0;
                    r_status <= ST_WRITTEN;
                end
            end
            S_WALK: begin
                if (w_hit && w_first) begin
                    r_result <= w_val;
                    r_status <= ST_CLAMP_LO;
                end else if (w_hit) begin
                    r_num <= DATA_W'({r_q[DATA_W-1], r_q} - {r_k0[DATA_W-1], r_k0});
                    r_den <= DATA_W'({w_key[DATA_W-1], w_key} - {r_k0[DATA_W-1], r_k0});
                    r_dv  <= {w_val[DATA_W-1], w_val} - {r_v0[DATA_W-1], r_v0};
                end else if (w_last) begin
                    r_result <= w_val;
                    r_status <= ST_CLAMP_HI;
                end else begin
                    r_k0  <= w_key;
                    r_v0  <= w_val;
                    r_idx <= TBL_AW'(r_idx + 1'b1);
                end
            end
            S_PREP: begin
                r_neg <= r_dv[DATA_W];
                r_mag <= r_dv[DATA_W] ? DATA_W'((DATA_W + 1)'(0) - r_dv) : r_dv[DATA_W-1:0];
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    r_result <= r_neg ? DATA_W'(r_v0 - w_div_rsp.quotient)
                                      : DATA_W'(r_v0 + w_div_rsp.quotient);
                    r_status <= ST_INTERP;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done         = r_done;
    assign o_result_value = r_result;
    assign o_status       = r_status;

endmodule
